// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- src/oaht_pkg.sv -----
// Shared types, constants and helpers of the open-addressing hash table.
package oaht_pkg;
	localparam int CAPACITY_DEF   = 1024;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int VALUE_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [63:0] HASH_MULT = 64'd431;

	localparam logic [10:0] MAX_USAGE_RST  = 11'd716;
	localparam logic [10:0] MAX_PROBES_RST = 11'd1024;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_UPDATE = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2,
		ST_LIMIT = 2'd3
	} status_t;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	localparam logic REG_MAX_USAGE  = 1'b0;
	localparam logic REG_MAX_PROBES = 1'b1;

	// Sign-extended byte i of the key, plus one.
	function automatic logic [63:0] hash_term(input logic [63:0] key, input logic [2:0] idx);
		logic [7:0] b;
		b = key[{idx, 3'b000} +: 8];
		return {{56{b[7]}}, b} + 64'd1;
	endfunction
endpackage

// ----- src/oaht_ram.sv -----
// Generic single-port RAM with registered read.
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- src/oaht_front.sv -----
// Front end: accepts requests, hashes the key one byte a cycle, queues jobs.
module oaht_front #(
	parameter int KEY_BYTES  = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             operation,
	input  logic [63:0]            key,
	input  logic [31:0]            value,
	output logic                   job_valid,
	input  logic                   job_ready,
	output logic [1:0]             job_op,
	output logic [8*KEY_BYTES-1:0] job_key,
	output logic [VALUE_BITS-1:0]  job_val,
	output logic [63:0]            job_code
);
	import oaht_pkg::*;

	localparam int KW  = 8 * KEY_BYTES;
	localparam int JW  = 2 + KW + VALUE_BITS + 64;
	localparam int QAW = $clog2(QUEUE_DEPTH);

	typedef enum logic { H_IDLE, H_RUN } hstate_t;

	hstate_t          state_q;
	logic [2:0]       byte_q;
	logic [63:0]      code_q;
	logic [1:0]       op_q;
	logic [KW-1:0]    key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [63:0]      sum;
	logic [63:0]      prod;

	logic [JW-1:0]    fifo_q [QUEUE_DEPTH];
	logic [QAW-1:0]   wp_q, rp_q;
	logic [QAW:0]     cnt_q;
	logic             push, pop, last;

	assign sum  = code_q + hash_term({{(64-KW){1'b0}}, key_q}, byte_q);
	assign prod = sum * HASH_MULT;
	assign last = (byte_q == 3'(KEY_BYTES - 1));
	assign push = (state_q == H_RUN) && last;
	assign pop  = job_valid && job_ready;
	assign in_ready = (state_q == H_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			byte_q  <= '0;
		end else begin
			case (state_q)
				H_IDLE: begin
					if (in_valid) begin
						state_q <= H_RUN;
						byte_q  <= '0;
					end
				end
				H_RUN: begin
					if (last) begin
						if (cnt_q < (QAW+1)'(QUEUE_DEPTH) || pop) begin
							state_q <= H_IDLE;
						end
					end else begin
						byte_q <= byte_q + 3'd1;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	logic push_ok;
	assign push_ok = push && (cnt_q < (QAW+1)'(QUEUE_DEPTH) || pop);

	always_ff @(posedge clk) begin
		if (state_q == H_IDLE && in_valid) begin
			op_q   <= operation;
			key_q  <= key[KW-1:0];
			val_q  <= value[VALUE_BITS-1:0];
			code_q <= '0;
		end else if (state_q == H_RUN && !last) begin
			code_q <= prod;
		end
		if (push_ok) begin
			fifo_q[wp_q] <= {op_q, key_q, val_q, prod};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) wp_q <= (wp_q == QAW'(QUEUE_DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)     rp_q <= (rp_q == QAW'(QUEUE_DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push_ok) - (QAW+1)'(pop);
		end
	end

	assign job_valid = (cnt_q != '0);
	assign {job_op, job_key, job_val, job_code} = fifo_q[rp_q];

	`include "assert_macros.svh"
	`ASSERT_NEVER(a_queue_over, clk, arst_n, cnt_q > (QAW+1)'(QUEUE_DEPTH))
	`ASSERT_CLK(a_push_room, clk, arst_n, (push && cnt_q == (QAW+1)'(QUEUE_DEPTH) && !pop) |=> (state_q == H_RUN))
	`ASSERT_CLK(a_take_idle, clk, arst_n, (in_valid && in_ready) |=> (state_q == H_RUN))
endmodule

// ----- src/oaht_back.sv -----
// Back end: probes the slot stores, applies the operation, holds the result.
module oaht_back #(
	parameter int CAPACITY   = 1024,
	parameter int KEY_BYTES  = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [10:0]            max_usage,
	input  logic [10:0]            max_probes,
	input  logic                   job_valid,
	output logic                   job_ready,
	input  logic [1:0]             job_op,
	input  logic [8*KEY_BYTES-1:0] job_key,
	input  logic [VALUE_BITS-1:0]  job_val,
	input  logic [63:0]            job_code,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic                   found,
	output logic [31:0]            read_value,
	output logic [9:0]             slot_index,
	output logic [10:0]            live_count
);
	import oaht_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int KW = 8 * KEY_BYTES;
	localparam int CW = AW + 1;

	typedef enum logic [2:0] { B_IDLE, B_CLEAR, B_ADDR, B_READ, B_EVAL, B_ACT, B_OUT } bstate_t;

	bstate_t               state_q;
	logic [AW-1:0]         clr_q;
	logic [10:0]           p_q;
	logic [AW-1:0]         k_q;
	logic [AW-1:0]         at_q, tomb_at_q;
	logic                  tomb_seen_q;
	logic [1:0]            op_q;
	logic [KW-1:0]         key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0]         code_q;
	logic [CW-1:0]         count_q;

	logic                  m_we, k_we, v_we;
	logic [AW-1:0]         m_addr;
	logic [1:0]            m_wd, m_rd;
	logic [KW-1:0]         k_rd;
	logic [VALUE_BITS-1:0] v_rd, v_wd;
	logic [AW-1:0]         sq, pos;

	oaht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_marks (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
	oaht_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_keys (
		.clk(clk), .we(k_we), .addr(m_addr), .wdata(key_q), .rdata(k_rd));
	oaht_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
		.clk(clk), .we(v_we), .addr(m_addr), .wdata(v_wd), .rdata(v_rd));

	// offset k*k mod capacity; k below capacity keeps the product narrow
	assign sq  = AW'(k_q * k_q);
	assign pos = p_q[0] ? code_q - sq : code_q + sq;

	logic hit, full, do_ins;
	assign hit    = (m_rd == MARK_LIVE) && (k_rd == key_q);
	assign full   = (32'(count_q) >= 32'(max_usage));

	assign job_ready = (state_q == B_IDLE);

	always_comb begin
		m_we = 1'b0; k_we = 1'b0; v_we = 1'b0;
		m_wd = MARK_EMPTY; v_wd = val_q;
		m_addr = at_q;
		do_ins = 1'b0;
		case (state_q)
			B_CLEAR: begin
				m_we = 1'b1; m_addr = clr_q;
			end
			B_ADDR: m_addr = pos;
			B_READ: m_addr = at_q;
			B_ACT: begin
				if (found) begin
					if (op_q == OP_INSERT || op_q == OP_UPDATE) v_we = 1'b1;
					if (op_q == OP_REMOVE) begin
						m_we = 1'b1; m_wd = MARK_TOMB;
					end
				end else if (status == ST_DONE) begin
					do_ins = 1'b1;
					m_addr = tomb_seen_q ? tomb_at_q : at_q;
					m_we = 1'b1; k_we = 1'b1; v_we = 1'b1; m_wd = MARK_LIVE;
				end
			end
			default: m_addr = at_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CAPACITY-1)) state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (job_valid) begin
						op_q <= job_op; key_q <= job_key; val_q <= job_val;
						code_q <= job_code[AW-1:0];
						p_q <= '0; k_q <= '0; tomb_seen_q <= 1'b0;
						status <= ST_LIMIT; found <= 1'b0;
						read_value <= '0; slot_index <= '0;
						state_q <= (max_probes == '0) ? B_ACT : B_ADDR;
					end
				end
				B_ADDR: begin
					at_q <= pos;
					state_q <= B_READ;
				end
				B_READ: state_q <= B_EVAL;
				B_EVAL: begin
					state_q <= B_ACT;
					if (m_rd == MARK_EMPTY) begin
						if (op_q == OP_INSERT) begin
							if (full) status <= ST_FULL;
							else begin
								status <= ST_DONE;
								slot_index <= 10'(tomb_seen_q ? tomb_at_q : at_q);
							end
						end else status <= ST_MISS;
					end else if (hit) begin
						status <= ST_DONE; found <= 1'b1;
						slot_index <= 10'(at_q);
					end else begin
						if (m_rd != MARK_LIVE && !tomb_seen_q) begin
							tomb_seen_q <= 1'b1; tomb_at_q <= at_q;
						end
						if (p_q + 11'd1 < max_probes) begin
							p_q <= p_q + 11'd1;
							if (!p_q[0]) k_q <= k_q + 1'b1;
							state_q <= B_ADDR;
						end
					end
				end
				B_ACT: begin
					if (found) begin
						if (op_q == OP_LOOKUP) read_value <= 32'(v_rd);
						if (op_q == OP_REMOVE && count_q != '0) count_q <= count_q - 1'b1;
					end else if (do_ins) count_q <= count_q + 1'b1;
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign live_count = 11'(count_q);

	`include "assert_macros.svh"
	`ASSERT_NEVER(a_count_cap, clk, arst_n, count_q > CW'(CAPACITY))
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid)
	`ASSERT_CLK(a_insert_room, clk, arst_n, (state_q == B_ACT && do_ins) |-> ({1'b0, live_count} < {1'b0, max_usage}))
endmodule

// ----- src/open_addressing_hash_table.sv -----
// Top level of the open-addressing hash table with quadratic probing.
//
// channel   dir  handshake              payload
// request   in   in_valid / in_ready    operation, key, value
// result    out  out_valid / out_ready  status, found, read_value, slot_index, live_count
// config    in   APB (psel/penable)     max_usage @0x0, max_probes @0x4
//
// The front hashes one key byte a cycle and queues up to two hashed
// requests. The back takes a request, steps through the address, RAM read
// and compare states for each probed slot, applies the request, then
// raises and hands over the result; it takes no new request until that
// result is taken, so the probe loop sets the rate. After reset the back
// sweeps every slot mark to empty before it takes its first request; the
// front already accepts and queues. A stalled result stays in the output
// register; the front keeps hashing until its queue is full.
module open_addressing_hash_table #(
	parameter int CAPACITY   = oaht_pkg::CAPACITY_DEF,
	parameter int KEY_BYTES  = oaht_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic [31:0] read_value,
	output logic [9:0]  slot_index,
	output logic [10:0] live_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import oaht_pkg::*;

	localparam int KW = 8 * KEY_BYTES;

	logic [10:0] max_usage_q, max_probes_q;
	logic                  job_valid, job_ready;
	logic [1:0]            job_op;
	logic [KW-1:0]         job_key;
	logic [VALUE_BITS-1:0] job_val;
	logic [63:0]           job_code;

	// configuration registers; write lands in the access phase
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_usage_q  <= MAX_USAGE_RST;
			max_probes_q <= MAX_PROBES_RST;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_MAX_USAGE) max_usage_q <= pwdata[10:0];
			else                            max_probes_q <= pwdata[10:0];
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_USAGE:  prdata = {21'd0, max_usage_q};
			REG_MAX_PROBES: prdata = {21'd0, max_probes_q};
			default:        prdata = '0;
		endcase
	end

	oaht_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .key(key), .value(value),
		.job_valid(job_valid), .job_ready(job_ready),
		.job_op(job_op), .job_key(job_key), .job_val(job_val), .job_code(job_code)
	);

	oaht_back #(.CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.max_usage(max_usage_q), .max_probes(max_probes_q),
		.job_valid(job_valid), .job_ready(job_ready),
		.job_op(job_op), .job_key(job_key), .job_val(job_val), .job_code(job_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found), .read_value(read_value),
		.slot_index(slot_index), .live_count(live_count)
	);
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the open-addressing hash table.
module testbench;
	import oaht_pkg::*;

	// One result as the block reports it.
	typedef struct packed {
		status_t     st;
		logic        hit;
		logic [31:0] rd;
		logic [9:0]  slot;
		logic [10:0] live;
	} answer_t;

	typedef enum logic {ROW_REQUEST, ROW_SETTING} row_kind_t;

	// One row of the directed stimulus: a request or a register write.
	typedef struct {
		row_kind_t   kind;
		op_t         op;
		logic [63:0] k;
		logic [31:0] v;
		logic        reg_idx;
		bit          typed;
		answer_t     want;
	} row_t;

	typedef struct {
		int mu;
		int mp;
		int n;
	} phase_t;

	localparam int CAP      = 1024;
	localparam int HOLD_CYC = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [63:0] key;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        found;
	logic [31:0] read_value;
	logic [9:0]  slot_index;
	logic [10:0] live_count;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	open_addressing_hash_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .key(key), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found), .read_value(read_value),
		.slot_index(slot_index), .live_count(live_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the table contents and registers.
	logic [1:0]  shadow_mark [CAP];
	logic [63:0] shadow_key  [CAP];
	logic [31:0] shadow_val  [CAP];
	int          shadow_count;
	int          usage_limit;
	int          probe_limit;

	answer_t     pending_answers[$];
	int          errors;
	int          n_results;
	int          status_seen[4];
	bit          idle_on;
	bit          hold_req;

	// Key pools: three clusters of keys sharing one home slot each,
	// plus a larger pool of unrelated keys so hits are frequent.
	logic [63:0] cluster_keys[24];
	logic [63:0] pool_keys[200];
	row_t        rows[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Byte-wise multiplicative hash, bytes sign-extended.
	function automatic logic [63:0] key_code(input logic [63:0] k);
		logic [63:0] code;
		logic [63:0] b;
		code = 64'd0;
		for (int i = 0; i < 8; i++) begin
			b = {{56{k[8*i+7]}}, k[8*i +: 8]};
			code = (code + b + 64'd1) * 64'd431;
		end
		return code;
	endfunction

	// Quadratic probe order: home, -1, +1, -4, +4, -9, ...
	function automatic int probe_at(input logic [63:0] code, input int p);
		logic [63:0] step;
		logic [63:0] pos;
		step = 64'((p + 1) / 2);
		step = step * step;
		pos = p[0] ? code - step : code + step;
		return int'(pos[9:0]);
	endfunction

	// Applies one request to the shadow table and returns what the block owes.
	function automatic answer_t table_apply(input op_t op, input logic [63:0] k,
			input logic [31:0] v);
		answer_t     a;
		logic [63:0] code;
		bit          hit, empty_seen, tomb_seen;
		int          at, tomb_at, s, w;
		a = '{st: ST_LIMIT, hit: 1'b0, rd: '0, slot: '0, live: '0};
		code = key_code(k);
		hit = 0;
		empty_seen = 0;
		tomb_seen = 0;
		at = 0;
		tomb_at = 0;
		for (int p = 0; p < probe_limit; p++) begin
			s = probe_at(code, p);
			if (shadow_mark[s] == MARK_EMPTY) begin
				empty_seen = 1;
				at = s;
				break;
			end
			if (shadow_mark[s] == MARK_LIVE) begin
				if (shadow_key[s] == k) begin
					hit = 1;
					at = s;
					break;
				end
			end else if (!tomb_seen) begin
				tomb_seen = 1;
				tomb_at = s;
			end
		end
		if (hit) begin
			a.hit = 1'b1;
			a.slot = at[9:0];
			a.st = ST_DONE;
			case (op)
				OP_LOOKUP: a.rd = shadow_val[at];
				OP_INSERT, OP_UPDATE: shadow_val[at] = v;
				default: begin
					shadow_mark[at] = MARK_TOMB;
					if (shadow_count > 0)
						shadow_count--;
				end
			endcase
		end else if (empty_seen) begin
			if (op != OP_INSERT) begin
				a.st = ST_MISS;
			end else if (shadow_count >= usage_limit) begin
				a.st = ST_FULL;
			end else begin
				w = tomb_seen ? tomb_at : at;
				shadow_mark[w] = MARK_LIVE;
				shadow_key[w] = k;
				shadow_val[w] = v;
				shadow_count++;
				a.slot = w[9:0];
				a.st = ST_DONE;
			end
		end
		a.live = shadow_count[10:0];
		return a;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!idle_on || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(4, 1);
		return $urandom_range(80, 20);
	endfunction

	// Result side: check at the rising edge, steer out_ready at the falling edge.
	initial begin
		int      stall_left;
		answer_t w;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				n_results++;
				if (pending_answers.size() == 0) begin
					report("result with nothing pending", {status, found}, 0);
				end else begin
					w = pending_answers.pop_front();
					status_seen[w.st]++;
					if (status !== w.st)     report("status", status, w.st);
					if (found !== w.hit)     report("found", found, w.hit);
					if (read_value !== w.rd) report("read_value", read_value, w.rd);
					if (slot_index !== w.slot) report("slot_index", slot_index, w.slot);
					if (live_count !== w.live) report("live_count", live_count, w.live);
				end
			end
			@(negedge clk);
			if (hold_req) begin
				// long back-pressure: block fills and drops in_ready
				hold_req = 0;
				stall_left = HOLD_CYC;
			end else if (stall_left == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offers one request starting at a falling edge; returns at a falling edge.
	task automatic send_request(input op_t op, input logic [63:0] k, input logic [31:0] v,
			input bit typed, input answer_t want);
		answer_t a;
		int      gap;
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		a = table_apply(op, k, v);
		pending_answers.push_back(typed ? want : a);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Register write (setup + access) followed by a read back.
	task automatic write_setting(input logic idx, input int v);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(v))
			report("register read back", prdata, 32'(v));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_MAX_USAGE)
			usage_limit = v;
		else
			probe_limit = v;
	endtask

	function automatic row_t req_row(input op_t op, input logic [63:0] k,
			input logic [31:0] v);
		return '{kind: ROW_REQUEST, op: op, k: k, v: v, reg_idx: 1'b0, typed: 0,
			want: '0};
	endfunction

	function automatic row_t typed_row(input op_t op, input logic [63:0] k,
			input status_t st, input int live);
		return '{kind: ROW_REQUEST, op: op, k: k, v: 32'h5a5a_a5a5, reg_idx: 1'b0,
			typed: 1, want: '{st: st, hit: 1'b0, rd: '0, slot: '0, live: 11'(live)}};
	endfunction

	function automatic row_t setting_row(input logic idx, input int v);
		return '{kind: ROW_SETTING, op: OP_LOOKUP, k: '0, v: 32'(v), reg_idx: idx,
			typed: 0, want: '0};
	endfunction

	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return {$urandom, $urandom};
		if (r <= 8)
			return cluster_keys[$urandom_range(23)];
		return pool_keys[$urandom_range(199)];
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(9);
		if (r < 4) return OP_INSERT;
		if (r < 6) return OP_LOOKUP;
		if (r < 7) return OP_UPDATE;
		return OP_REMOVE;
	endfunction

	initial begin
		phase_t      phases[8];
		logic [63:0] k;
		int          home;
		int          got;
		row_t        r;

		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_LOOKUP;
		key = '0;
		value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		n_results = 0;
		idle_on = 1;
		hold_req = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (shadow_mark[i]) begin
			shadow_mark[i] = MARK_EMPTY;
			shadow_key[i] = '0;
			shadow_val[i] = '0;
		end
		shadow_count = 0;
		usage_limit = int'(MAX_USAGE_RST);
		probe_limit = int'(MAX_PROBES_RST);

		// find keys that collide on a home slot, eight per cluster
		for (int c = 0; c < 3; c++) begin
			home = $urandom_range(CAP - 1);
			got = 0;
			while (got < 8) begin
				k = {$urandom, $urandom};
				if (int'(key_code(k) & 64'h3ff) == home) begin
					cluster_keys[c*8 + got] = k;
					got++;
				end
			end
		end
		foreach (pool_keys[i]) pool_keys[i] = {$urandom, $urandom};

		// directed part: empty table, extremes, sign bytes, tombstone reuse,
		// load limit, probe limit of one and zero
		rows.push_back(typed_row(OP_LOOKUP, 64'd0, ST_MISS, 0));
		rows.push_back(typed_row(OP_UPDATE, 64'd0, ST_MISS, 0));
		rows.push_back(typed_row(OP_REMOVE, 64'd0, ST_MISS, 0));
		rows.push_back(req_row(OP_INSERT, 64'd0, 32'd0));
		rows.push_back(req_row(OP_INSERT, '1, '1));
		rows.push_back(req_row(OP_LOOKUP, '1, 32'd0));
		rows.push_back(req_row(OP_INSERT, 64'd0, 32'h1234_5678));
		rows.push_back(req_row(OP_UPDATE, 64'd0, 32'hdead_beef));
		rows.push_back(req_row(OP_LOOKUP, 64'd0, 32'd0));
		rows.push_back(req_row(OP_INSERT, 64'h8080_8080_8080_8080, 32'h8000_0000));
		rows.push_back(req_row(OP_INSERT, 64'h7f7f_7f7f_7f7f_7f7f, 32'h7fff_ffff));
		rows.push_back(req_row(OP_REMOVE, 64'd0, 32'd0));
		rows.push_back(req_row(OP_LOOKUP, 64'd0, 32'd0));
		rows.push_back(req_row(OP_INSERT, cluster_keys[0], 32'd10));
		rows.push_back(req_row(OP_INSERT, cluster_keys[1], 32'd11));
		rows.push_back(req_row(OP_INSERT, cluster_keys[2], 32'd12));
		rows.push_back(req_row(OP_REMOVE, cluster_keys[1], 32'd0));
		rows.push_back(req_row(OP_LOOKUP, cluster_keys[2], 32'd0));
		rows.push_back(req_row(OP_INSERT, cluster_keys[3], 32'd13));
		rows.push_back(setting_row(REG_MAX_USAGE, 0));
		rows.push_back(typed_row(OP_INSERT, 64'd1, ST_FULL, 6));
		rows.push_back(req_row(OP_INSERT, cluster_keys[2], 32'd22));
		rows.push_back(setting_row(REG_MAX_PROBES, 1));
		rows.push_back(req_row(OP_LOOKUP, cluster_keys[2], 32'd0));
		rows.push_back(req_row(OP_INSERT, cluster_keys[4], 32'd14));
		rows.push_back(setting_row(REG_MAX_PROBES, 0));
		rows.push_back(typed_row(OP_LOOKUP, 64'd0, ST_LIMIT, 6));
		rows.push_back(setting_row(REG_MAX_USAGE, 1024));
		rows.push_back(setting_row(REG_MAX_PROBES, 1024));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_SETTING)
				write_setting(r.reg_idx, int'(r.v));
			else
				send_request(r.op, r.k, r.v, r.typed, r.want);
		end

		// random part, one pair of register settings per phase
		phases[0] = '{mu: 716,  mp: 1024, n: 350};
		phases[1] = '{mu: 1024, mp: 1024, n: 350};
		phases[2] = '{mu: 30,   mp: 1024, n: 250};
		phases[3] = '{mu: 1024, mp: 2,    n: 250};
		phases[4] = '{mu: 12,   mp: 1,    n: 200};
		phases[5] = '{mu: 1024, mp: 2047, n: 150};
		phases[6] = '{mu: 0,    mp: 5,    n: 60};
		phases[7] = '{mu: 1024, mp: 1024, n: 290};
		foreach (phases[p]) begin
			write_setting(REG_MAX_USAGE, phases[p].mu);
			write_setting(REG_MAX_PROBES, phases[p].mp);
			idle_on = (p % 3) != 1;
			for (int i = 0; i < phases[p].n; i++) begin
				if (p == 0 && i == 100)
					hold_req = 1;
				if (p == 2 && i == 120) begin
					// sender waits for every outstanding result
					in_valid <= 1'b0;
					while (pending_answers.size() != 0)
						@(negedge clk);
				end
				send_request(pick_op(), pick_key(), $urandom, 0, '0);
			end
		end

		drain();
		repeat (100) @(negedge clk);
		$display("covered %0d results: %0d done, %0d miss, %0d full, %0d probe limit",
			n_results, status_seen[ST_DONE], status_seen[ST_MISS],
			status_seen[ST_FULL], status_seen[ST_LIMIT]);
		$display("load limits 0..1024 and probe limits 0..2047, %0d live at the end",
			shadow_count);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
